@@ sv/assert_macros.svh @@
// Assertion macros shared by the perspective warp RTL.
// No dependencies; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define PWB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
// The condition must never be seen at a clock edge outside reset.
`define PWB_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PWB_ASSERT(lbl, clk, rst, prop)
`define PWB_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ sv/pwb_pkg.sv @@
// Shared types and constants of the perspective warp block.
// No dependencies.
package pwb_pkg;

  localparam int CoefW    = 32;
  localparam int PixW     = 32;
  localparam int ByteW    = 8;
  localparam int CoordW   = 8;
  localparam int FracW    = 8;
  localparam int MagW     = 20;
  localparam int SizeW    = 9;
  localparam int ChW      = 3;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;
  localparam int QueueDepth = 4;

  localparam logic [CfgDataW-1:0] CoefOne = 64'd1048576;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_WARP = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAIR_A   = 3'd0,
    REG_PAIR_B   = 3'd1,
    REG_PAIR_C   = 3'd2,
    REG_PAIR_D   = 3'd3,
    REG_LAST     = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_CHANNELS = 3'd7
  } cfg_reg_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic signed [CoefW-1:0] m00;
    logic signed [CoefW-1:0] m01;
    logic signed [CoefW-1:0] m02;
    logic signed [CoefW-1:0] m10;
    logic signed [CoefW-1:0] m11;
    logic signed [CoefW-1:0] m12;
    logic signed [CoefW-1:0] m20;
    logic signed [CoefW-1:0] m21;
    logic signed [CoefW-1:0] m22;
    logic [SizeW-1:0]        width;
    logic [SizeW-1:0]        height;
    logic [ChW-1:0]          channels;
  } cfg_t;

  // Classified request handed from the mapping front to the blending back.
  typedef struct packed {
    logic              is_load;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   data;
    logic              black;
    logic              neg_r;
    logic [MagW-1:0]   mag_r;
    logic              neg_c;
    logic [MagW-1:0]   mag_c;
  } fitem_t;

endpackage

@@ sv/pwb_in_if.sv @@
// Input request channel of the perspective warp block.
// Depends on pwb_pkg for field widths.
interface pwb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [pwb_pkg::CoordW-1:0]   pix_row;
  logic [pwb_pkg::CoordW-1:0]   pix_col;
  logic [pwb_pkg::PixW-1:0]     load_value;

  modport source(output valid, op, pix_row, pix_col, load_value, input ready);
  modport sink(input valid, op, pix_row, pix_col, load_value, output ready);
endinterface

@@ sv/pwb_out_if.sv @@
// Result channel of the perspective warp block.
// Depends on pwb_pkg for field widths.
interface pwb_out_if;
  logic                       valid;
  logic                       ready;
  logic [pwb_pkg::PixW-1:0]   out_pixel;
  logic                       inside_res;

  modport source(output valid, out_pixel, inside_res, input ready);
  modport sink(input valid, out_pixel, inside_res, output ready);
endinterface

@@ sv/pwb_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pwb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pwb_front.sv @@
// Mapping front: accepts requests, forms the projective numerators and divisor,
// and divides them in a bit-per-stage pipeline. Depends on pwb_pkg and pwb_in_if.
module pwb_front #(
  parameter int QBits = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  pwb_pkg::cfg_t    cfg,
  pwb_in_if.sink           pix_in,
  output logic             item_valid,
  input  logic             item_ready,
  output pwb_pkg::fitem_t  item
);

  localparam int ProdW = pwb_pkg::CoefW + pwb_pkg::CoordW + 1;
  localparam int SumW  = ProdW + 2;
  localparam int NumW  = SumW + pwb_pkg::FracW;
  localparam int CmpW  = (NumW > SumW + QBits) ? NumW : SumW + QBits;

  logic fen;
  logic signed [pwb_pkg::CoordW:0] rs;
  logic signed [pwb_pkg::CoordW:0] cs;

  pwb_pkg::fitem_t         s1_item_next;
  logic                    s1_valid;
  pwb_pkg::fitem_t         s1_item;
  logic signed [ProdW-1:0] s1_prod [6];

  logic                   s2_valid;
  pwb_pkg::fitem_t        s2_item;
  logic signed [SumW-1:0] s2_nr;
  logic signed [SumW-1:0] s2_nc;
  logic signed [SumW-1:0] s2_den;

  logic signed [NumW-1:0] nr_s;
  logic signed [NumW-1:0] nc_s;
  logic [NumW-1:0]        nr_m;
  logic [NumW-1:0]        nc_m;
  logic [SumW-1:0]        d_m;
  logic [CmpW-1:0]        d_top;
  logic                   ovf;
  logic                   den_zero;
  pwb_pkg::fitem_t        dv_item_next;

  logic            dv_valid [QBits+1];
  pwb_pkg::fitem_t dv_item  [QBits+1];
  logic [NumW-1:0] dv_rr    [QBits+1];
  logic [NumW-1:0] dv_rc    [QBits+1];
  logic [SumW-1:0] dv_d     [QBits+1];
  logic [QBits-1:0] dv_qr   [QBits+1];
  logic [QBits-1:0] dv_qc   [QBits+1];

  // The whole front advances together unless its last stage is blocked.
  assign fen          = !dv_valid[QBits] || item_ready;
  assign pix_in.ready = fen;

  assign rs = $signed({1'b0, pix_in.pix_row});
  assign cs = $signed({1'b0, pix_in.pix_col});

  // Request fields carried along with the arithmetic.
  always_comb begin
    s1_item_next         = '0;
    s1_item_next.is_load = (pix_in.op == pwb_pkg::OP_LOAD);
    s1_item_next.row     = pix_in.pix_row;
    s1_item_next.col     = pix_in.pix_col;
    s1_item_next.data    = pix_in.load_value;
  end

  // Stage 1: coefficient times coordinate products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fen) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      s1_item         <= s1_item_next;
      s1_prod[0]      <= cfg.m00 * rs;
      s1_prod[1]      <= cfg.m01 * cs;
      s1_prod[2]      <= cfg.m10 * rs;
      s1_prod[3]      <= cfg.m11 * cs;
      s1_prod[4]      <= cfg.m20 * rs;
      s1_prod[5]      <= cfg.m21 * cs;
    end
  end

  // Stage 2: numerators and divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (fen) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      s2_item <= s1_item;
      s2_nr   <= SumW'(s1_prod[0]) + SumW'(s1_prod[1]) + SumW'(cfg.m02);
      s2_nc   <= SumW'(s1_prod[2]) + SumW'(s1_prod[3]) + SumW'(cfg.m12);
      s2_den  <= SumW'(s1_prod[4]) + SumW'(s1_prod[5]) + SumW'(cfg.m22);
    end
  end

  // Stage 3: magnitudes, quotient signs and the range check that bounds the quotient.
  assign nr_s     = NumW'(s2_nr) <<< pwb_pkg::FracW;
  assign nc_s     = NumW'(s2_nc) <<< pwb_pkg::FracW;
  assign nr_m     = nr_s[NumW-1] ? $unsigned(-nr_s) : $unsigned(nr_s);
  assign nc_m     = nc_s[NumW-1] ? $unsigned(-nc_s) : $unsigned(nc_s);
  assign d_m      = s2_den[SumW-1] ? $unsigned(-s2_den) : $unsigned(s2_den);
  assign d_top    = CmpW'(d_m) << QBits;
  assign ovf      = (CmpW'(nr_m) >= d_top) || (CmpW'(nc_m) >= d_top);
  assign den_zero = (s2_den == '0);

  // Classification added to the request before the divider.
  always_comb begin
    dv_item_next       = s2_item;
    dv_item_next.black = den_zero || ovf;
    dv_item_next.neg_r = nr_s[NumW-1] ^ s2_den[SumW-1];
    dv_item_next.neg_c = nc_s[NumW-1] ^ s2_den[SumW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (fen) begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      dv_item[0]       <= dv_item_next;
      dv_rr[0]         <= nr_m;
      dv_rc[0]         <= nc_m;
      dv_d[0]          <= d_m;
      dv_qr[0]         <= '0;
      dv_qc[0]         <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, row and column side by side.
  for (genvar k = 0; k < QBits; k++) begin : g_div
    localparam int Sh = QBits - 1 - k;
    logic [CmpW-1:0] dsh;
    logic [CmpW-1:0] rr;
    logic [CmpW-1:0] rc;
    logic            ge_r;
    logic            ge_c;

    assign dsh  = CmpW'(dv_d[k]) << Sh;
    assign rr   = CmpW'(dv_rr[k]);
    assign rc   = CmpW'(dv_rc[k]);
    assign ge_r = (rr >= dsh);
    assign ge_c = (rc >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (fen) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (fen) begin
        dv_item[k+1] <= dv_item[k];
        dv_d[k+1]    <= dv_d[k];
        dv_rr[k+1]   <= ge_r ? NumW'(rr - dsh) : dv_rr[k];
        dv_rc[k+1]   <= ge_c ? NumW'(rc - dsh) : dv_rc[k];
        dv_qr[k+1]   <= {dv_qr[k][QBits-2:0], ge_r};
        dv_qc[k+1]   <= {dv_qc[k][QBits-2:0], ge_c};
      end
    end
  end

  // Hand the finished quotient magnitudes to the queue.
  assign item_valid = dv_valid[QBits];

  always_comb begin
    item       = dv_item[QBits];
    item.mag_r = pwb_pkg::MagW'(dv_qr[QBits]);
    item.mag_c = pwb_pkg::MagW'(dv_qc[QBits]);
  end

endmodule

@@ sv/pwb_queue.sv @@
// Short queue that decouples the mapping front from the blending back.
// Depends on pwb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pwb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pwb_pkg::fitem_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output pwb_pkg::fitem_t out_item
);

  localparam int Depth = pwb_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  pwb_pkg::fitem_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign out_valid = (count != '0);
  assign in_ready  = (count != CntW'(Depth)) || out_ready;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  `PWB_NEVER(a_q_over, clk, rst, count > CntW'(Depth))
  `PWB_NEVER(a_q_push_full, clk, rst, push && (count == CntW'(Depth)) && !pop)

endmodule

@@ sv/pwb_back.sv @@
// Blending back: writes loads into four parity banks, reads the four neighbors
// of a mapped position, blends them and registers the result. Depends on pwb_pkg,
// pwb_out_if, pwb_ram and assert_macros.svh.
`include "assert_macros.svh"
module pwb_back #(
  parameter int MaxWidth    = 256,
  parameter int MaxHeight   = 256,
  parameter int MaxChannels = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  pwb_pkg::cfg_t   cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  pwb_pkg::fitem_t item,
  pwb_out_if.source       pix_out
);

  localparam int RowW   = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int ColW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowHW  = (RowW > 1) ? RowW - 1 : 1;
  localparam int ColHW  = (ColW > 1) ? ColW - 1 : 1;
  localparam int AddrW  = RowHW + ColHW;
  localparam int BankDepth = 1 << AddrW;
  localparam int DimW   = 13;
  localparam int IntW   = pwb_pkg::MagW - pwb_pkg::FracW;
  localparam int WgtW   = pwb_pkg::FracW + 2;
  localparam int WW     = 2 * WgtW;
  localparam int PW     = WW + pwb_pkg::ByteW;
  localparam int VW     = PW + 2;
  localparam int Lanes  = pwb_pkg::PixW / pwb_pkg::ByteW;
  localparam logic [pwb_pkg::ByteW-1:0] ByteMax = '1;

  logic                        ben;
  logic [DimW-1:0]             w_sat;
  logic [DimW-1:0]             h_sat;
  logic [pwb_pkg::ChW-1:0]     nch;

  logic                        bad_r;
  logic                        bad_c;
  logic [IntW-1:0]             ir_m;
  logic [IntW-1:0]             ic_m;
  logic signed [WgtW-1:0]      fr;
  logic signed [WgtW-1:0]      fc;
  logic                        interior;
  logic [RowW-1:0]             ir_i;
  logic [RowW-1:0]             ir_n;
  logic [ColW-1:0]             ic_i;
  logic [ColW-1:0]             ic_n;
  logic [AddrW-1:0]            raddr [4];
  logic [RowW-1:0]             ld_r;
  logic [ColW-1:0]             ld_c;
  logic                        ld_ok;

  logic                        b1_valid;
  logic                        b1_load;
  logic                        b1_inside;
  logic signed [WgtW-1:0]      b1_fr;
  logic signed [WgtW-1:0]      b1_fc;
  logic                        b1_r0;
  logic                        b1_c0;
  logic [AddrW-1:0]            b1_raddr [4];
  logic [AddrW-1:0]            b1_waddr;
  logic [1:0]                  b1_wbank;
  logic                        b1_wok;
  logic [pwb_pkg::PixW-1:0]    b1_wdata;

  logic [3:0]                  bank_we;
  logic [pwb_pkg::PixW-1:0]    rdata [4];
  logic signed [WgtW-1:0]      ar;
  logic signed [WgtW-1:0]      ac;

  logic                        b2_valid;
  logic                        b2_inside;
  logic signed [WW-1:0]        b2_w [4];
  logic                        b2_r0;
  logic                        b2_c0;

  logic                        b3_valid;
  logic                        b3_inside;
  logic signed [PW-1:0]        b3_prod [Lanes][4];

  logic                        ov;
  logic [pwb_pkg::PixW-1:0]    pix_next;

  // The back advances whenever the output register is free or being taken.
  assign ben        = !ov || pix_out.ready;
  assign item_ready = ben;

  // Image size and channel count saturated to what the store holds.
  assign w_sat = (DimW'(cfg.width) > DimW'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(cfg.width);
  assign h_sat = (DimW'(cfg.height) > DimW'(MaxHeight)) ? DimW'(MaxHeight)
                                                         : DimW'(cfg.height);
  assign nch   = (cfg.channels > pwb_pkg::ChW'(MaxChannels)) ? pwb_pkg::ChW'(MaxChannels)
                                                             : cfg.channels;

  // Split the signed coordinates into integer part and fraction, both toward zero.
  // A small negative coordinate keeps integer part zero and a negative fraction.
  assign bad_r = item.neg_r && (item.mag_r[pwb_pkg::MagW-1:pwb_pkg::FracW] != '0);
  assign bad_c = item.neg_c && (item.mag_c[pwb_pkg::MagW-1:pwb_pkg::FracW] != '0);
  assign ir_m  = item.neg_r ? '0 : item.mag_r[pwb_pkg::MagW-1:pwb_pkg::FracW];
  assign ic_m  = item.neg_c ? '0 : item.mag_c[pwb_pkg::MagW-1:pwb_pkg::FracW];
  assign fr    = item.neg_r ? -$signed({2'b00, item.mag_r[pwb_pkg::FracW-1:0]})
                            : $signed({2'b00, item.mag_r[pwb_pkg::FracW-1:0]});
  assign fc    = item.neg_c ? -$signed({2'b00, item.mag_c[pwb_pkg::FracW-1:0]})
                            : $signed({2'b00, item.mag_c[pwb_pkg::FracW-1:0]});

  assign interior = !item.black && !bad_r && !bad_c
                 && ((DimW'(ir_m) + DimW'(1)) < h_sat)
                 && ((DimW'(ic_m) + DimW'(1)) < w_sat);

  assign ir_i = RowW'(ir_m);
  assign ir_n = ir_i + RowW'(1);
  assign ic_i = ColW'(ic_m);
  assign ic_n = ic_i + ColW'(1);

  // Each bank holds one row and column parity, so the four neighbors
  // always fall into four different banks.
  for (genvar b = 0; b < 4; b++) begin : g_addr
    localparam logic Pr = 1'((b >> 1) & 1);
    localparam logic Pc = 1'(b & 1);
    logic [RowW-1:0] row_sel;
    logic [ColW-1:0] col_sel;

    assign row_sel  = (ir_i[0] == Pr) ? ir_i : ir_n;
    assign col_sel  = (ic_i[0] == Pc) ? ic_i : ic_n;
    assign raddr[b] = {RowHW'(row_sel >> 1), ColHW'(col_sel >> 1)};
  end

  // Load target; loads beyond the store are dropped.
  assign ld_r  = RowW'(item.row);
  assign ld_c  = ColW'(item.col);
  assign ld_ok = (DimW'(item.row) < DimW'(MaxHeight)) && (DimW'(item.col) < DimW'(MaxWidth));

  // Stage B1: bank addresses and fractions.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (ben) begin
      b1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      b1_load   <= item.is_load;
      b1_inside <= interior;
      b1_fr     <= fr;
      b1_fc     <= fc;
      b1_r0     <= ir_i[0];
      b1_c0     <= ic_i[0];
      b1_raddr  <= raddr;
      b1_waddr  <= {RowHW'(ld_r >> 1), ColHW'(ld_c >> 1)};
      b1_wbank  <= {item.row[0], item.col[0]};
      b1_wok    <= ld_ok;
      b1_wdata  <= item.data;
    end
  end

  // Source store, banked by row and column parity.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign bank_we[b] = ben && b1_valid && b1_load && b1_wok && (b1_wbank == 2'(b));

    pwb_ram #(
      .Width (pwb_pkg::PixW),
      .Depth (BankDepth)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (b1_waddr),
      .wdata (b1_wdata),
      .re    (ben),
      .raddr (b1_raddr[b]),
      .rdata (rdata[b])
    );
  end

  // Stage B2: bilinear weights, alongside the bank reads.
  assign ar = WgtW'(256) - b1_fr;
  assign ac = WgtW'(256) - b1_fc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (ben) begin
      b2_valid <= b1_valid && !b1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      b2_inside <= b1_inside;
      b2_r0     <= b1_r0;
      b2_c0     <= b1_c0;
      b2_w[0]   <= ar * ac;
      b2_w[1]   <= ar * b1_fc;
      b2_w[2]   <= b1_fr * ac;
      b2_w[3]   <= b1_fr * b1_fc;
    end
  end

  // Stage B3: weight times channel value for every neighbor and channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else if (ben) begin
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      b3_inside <= b2_inside;
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    for (genvar n = 0; n < 4; n++) begin : g_nb
      localparam logic Dr = 1'((n >> 1) & 1);
      localparam logic Dc = 1'(n & 1);
      logic [pwb_pkg::PixW-1:0]  px;
      logic signed [pwb_pkg::ByteW:0] chv;

      assign px  = rdata[{b2_r0 ^ Dr, b2_c0 ^ Dc}];
      assign chv = $signed({1'b0, px[k*pwb_pkg::ByteW +: pwb_pkg::ByteW]});

      always_ff @(posedge clk) begin
        if (ben) begin
          b3_prod[k][n] <= b2_w[n] * chv;
        end
      end
    end
  end

  // Stage B4: channel sums, truncation, clamping and packing.
  for (genvar k = 0; k < Lanes; k++) begin : g_sum
    logic signed [VW-1:0]      v;
    logic [pwb_pkg::ByteW-1:0] bv;

    assign v  = VW'(b3_prod[k][0]) + VW'(b3_prod[k][1])
              + VW'(b3_prod[k][2]) + VW'(b3_prod[k][3]);
    assign bv = v[VW-1] ? '0
              : ((v[VW-2:2*pwb_pkg::FracW] > (VW-1-2*pwb_pkg::FracW)'(ByteMax)) ? ByteMax
                 : v[2*pwb_pkg::FracW +: pwb_pkg::ByteW]);
    assign pix_next[k*pwb_pkg::ByteW +: pwb_pkg::ByteW] =
      (b3_inside && (k < MaxChannels) && (pwb_pkg::ChW'(k) < nch)) ? bv : '0;
  end

  // Output register toward the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ben) begin
      ov <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      pix_out.out_pixel  <= pix_next;
      pix_out.inside_res <= b3_inside;
    end
  end

  assign pix_out.valid = ov;

  `PWB_ASSERT(a_bank_we_onehot, clk, rst, $onehot0(bank_we))

endmodule

@@ sv/perspective_warp_bilinear.sv @@
// Pipeline: 3 mapping stages, 8+clog2(max(MAX_WIDTH,MAX_HEIGHT)) divider stages,
// the queue and 4 blending stages. Throughput: one request per cycle, loads and
// warps alike, unless the result channel stalls; the divider and the four parity
// banks of the source store are fully pipelined. Reset clears all control state
// and sets the configuration to its defaults; the source store is not cleared;
// entries must be loaded before they are read; the block does not enforce it.
`include "assert_macros.svh"
module perspective_warp_bilinear #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pwb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pwb_pkg::CfgDataW-1:0]  cfg_data,
  pwb_in_if.sink                        pix_in,
  pwb_out_if.source                     pix_out
);

  localparam int MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QBits  = pwb_pkg::FracW + $clog2(MaxDim);

  logic [pwb_pkg::CfgDataW-1:0] pair_a;
  logic [pwb_pkg::CfgDataW-1:0] pair_b;
  logic [pwb_pkg::CfgDataW-1:0] pair_c;
  logic [pwb_pkg::CfgDataW-1:0] pair_d;
  logic [pwb_pkg::CoefW-1:0]    coef_last;
  logic [pwb_pkg::SizeW-1:0]    image_width;
  logic [pwb_pkg::SizeW-1:0]    image_height;
  logic [pwb_pkg::ChW-1:0]      channel_count;
  pwb_pkg::cfg_t                cfg;

  logic            fq_valid;
  logic            fq_ready;
  pwb_pkg::fitem_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  pwb_pkg::fitem_t qb_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_a        <= pwb_pkg::CoefOne;
      pair_b        <= '0;
      pair_c        <= pwb_pkg::CoefOne;
      pair_d        <= '0;
      coef_last     <= pwb_pkg::CoefOne[pwb_pkg::CoefW-1:0];
      image_width   <= pwb_pkg::SizeW'(256);
      image_height  <= pwb_pkg::SizeW'(256);
      channel_count <= pwb_pkg::ChW'(4);
    end else if (cfg_we) begin
      unique case (pwb_pkg::cfg_reg_t'(cfg_index))
        pwb_pkg::REG_PAIR_A:   pair_a        <= cfg_data;
        pwb_pkg::REG_PAIR_B:   pair_b        <= cfg_data;
        pwb_pkg::REG_PAIR_C:   pair_c        <= cfg_data;
        pwb_pkg::REG_PAIR_D:   pair_d        <= cfg_data;
        pwb_pkg::REG_LAST:     coef_last     <= cfg_data[pwb_pkg::CoefW-1:0];
        pwb_pkg::REG_WIDTH:    image_width   <= cfg_data[pwb_pkg::SizeW-1:0];
        pwb_pkg::REG_HEIGHT:   image_height  <= cfg_data[pwb_pkg::SizeW-1:0];
        pwb_pkg::REG_CHANNELS: channel_count <= cfg_data[pwb_pkg::ChW-1:0];
      endcase
    end
  end

  // Unpack the coefficient pairs.
  always_comb begin
    cfg.m00      = $signed(pair_a[31:0]);
    cfg.m01      = $signed(pair_a[63:32]);
    cfg.m02      = $signed(pair_b[31:0]);
    cfg.m10      = $signed(pair_b[63:32]);
    cfg.m11      = $signed(pair_c[31:0]);
    cfg.m12      = $signed(pair_c[63:32]);
    cfg.m20      = $signed(pair_d[31:0]);
    cfg.m21      = $signed(pair_d[63:32]);
    cfg.m22      = $signed(coef_last);
    cfg.width    = image_width;
    cfg.height   = image_height;
    cfg.channels = channel_count;
  end

  pwb_front #(
    .QBits (QBits)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_in     (pix_in),
    .item_valid (fq_valid),
    .item_ready (fq_ready),
    .item       (fq_item)
  );

  pwb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  pwb_back #(
    .MaxWidth    (MAX_WIDTH),
    .MaxHeight   (MAX_HEIGHT),
    .MaxChannels (MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (qb_valid),
    .item_ready (qb_ready),
    .item       (qb_item),
    .pix_out    (pix_out)
  );

  `PWB_ASSERT(a_black_outside, clk, rst, (pix_out.valid && !pix_out.inside_res) |-> (pix_out.out_pixel == '0))

endmodule
